// ----- hw/rtl/kgc_pkg.sv -----
// ----------------------------------------------------------------------------
// kgc_pkg
// Shared types and constants for the Koeppen-Geiger climate classifier:
// method codes, class codes, register map and the pipeline stage records.
// ----------------------------------------------------------------------------
package kgc_pkg;

    // Method register codes (code 3 acts as the original scheme)
    localparam logic [1:0] METHOD_ORIG     = 2'd0;
    localparam logic [1:0] METHOD_NO_SPLIT = 2'd1;
    localparam logic [1:0] METHOD_PEEL     = 2'd2;
    localparam logic [1:0] METHOD_RESET    = METHOD_NO_SPLIT;

    // Register index (word address)
    localparam logic REG_METHOD = 1'b0;

    // Month boundaries
    localparam logic [3:0] MONTH_MID_FIRST = 4'd3;
    localparam logic [3:0] MONTH_MID_LAST  = 4'd8;
    localparam logic [3:0] MONTH_LAST      = 4'd11;

    // Class codes
    localparam logic [4:0] CLASS_NONE = 5'd0;
    localparam logic [4:0] CLASS_AF   = 5'd1;
    localparam logic [4:0] CLASS_AM   = 5'd2;
    localparam logic [4:0] CLASS_AS   = 5'd3;
    localparam logic [4:0] CLASS_AW   = 5'd4;
    localparam logic [4:0] CLASS_BWK  = 5'd5;
    localparam logic [4:0] CLASS_BWH  = 5'd6;
    localparam logic [4:0] CLASS_BSK  = 5'd7;
    localparam logic [4:0] CLASS_BSH  = 5'd8;
    localparam logic [4:0] CLASS_CFA  = 5'd9;
    localparam logic [4:0] CLASS_DFA  = 5'd18;
    localparam logic [4:0] CLASS_ET   = 5'd30;
    localparam logic [4:0] CLASS_EF   = 5'd31;

    // Thresholds, temperatures in 0.1 C, rain in 0.1 mm
    localparam logic signed [10:0] T_WARM_MONTH   = 11'sd100;
    localparam logic signed [10:0] T_POLAR        = 11'sd100;
    localparam logic signed [10:0] T_TROPICAL     = 11'sd180;
    localparam logic signed [10:0] T_HOT_SUMMER   = 11'sd220;
    localparam logic signed [10:0] T_SNOW_SEVERE  = -11'sd380;
    localparam logic signed [10:0] T_COLD_ORIG    = -11'sd30;
    localparam logic signed [10:0] T_COLD_PEEL    = 11'sd0;
    localparam logic signed [14:0] T_SUM_HOT_ARID = 15'sd2160;
    localparam logic signed [18:0] ARID_OFS_K7    = 19'sd4200;
    localparam logic signed [18:0] ARID_OFS_K14   = 19'sd8400;
    localparam logic [15:0]        P_WET_MONTH    = 16'd600;
    localparam logic [21:0]        P_MONSOON      = 22'd25000;
    localparam logic [15:0]        P_DRY_SUM_ORIG = 16'd300;
    localparam logic [15:0]        P_DRY_SUM_PEEL = 16'd400;
    localparam logic [3:0]         WARM_MONTHS_B  = 4'd4;

    // Year totals captured when a pixel closes
    typedef struct packed {
        logic              missing;
        logic [13:0]       tsum_mid;
        logic [13:0]       tsum_edge;
        logic [10:0]       tlow;
        logic [10:0]       thigh;
        logic [3:0]        warm;
        logic [18:0]       rsum_mid;
        logic [18:0]       rsum_edge;
        logic [15:0]       rmin_mid;
        logic [15:0]       rmax_mid;
        logic [15:0]       rmin_edge;
        logic [15:0]       rmax_edge;
    } kgc_snap_t;

    // Compare results and operands for the final decision
    typedef struct packed {
        logic              missing;
        logic              polar_ef;
        logic              polar_et;
        logic              hot;
        logic [18:0]       arid_rhs;
        logic [19:0]       psum;
        logic              tropical;
        logic              trop_wet;
        logic              trop_monsoon;
        logic              trop_winter_dry;
        logic              dry_winter;
        logic              dry_summer;
        logic              pw_lt_ps;
        logic              temperate;
        logic              hot_summer;
        logic              warm4;
        logic              mild_winter;
    } kgc_deriv_t;

endpackage

// ----- hw/rtl/koppen_geiger_classifier_top.sv -----
// ----------------------------------------------------------------------------
// koppen_geiger_classifier_top
// Accumulates twelve monthly samples per pixel and emits one climate class
// when the closing month arrives.
// ----------------------------------------------------------------------------
// Throughput: one monthly sample per cycle while in_stall is low, no gaps between pixels.
// Path: the snapshot register loads with the month 11 transfer, then the
//   compare register and then the decision register, which is the output.
// Samples with month 12..15 are taken and dropped.
// Reset: accumulators hold an empty pixel, method register reads 1,
//   pipeline and output are empty.
module koppen_geiger_classifier_top (
    input  logic               clk,
    input  logic               rst_n,
    // sample channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         month,
    input  logic signed [10:0] temperature,
    input  logic [15:0]        precipitation,
    input  logic               no_data,
    // class channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [4:0]         climate_class,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [1:0] method_reg, method_next;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == kgc_pkg::REG_METHOD);

    always_comb
    begin
        method_next = method_reg;
        if (cfg_write)
        begin
            method_next = pwdata[1:0];
        end
    end

    assign prdata = (paddr[2] == kgc_pkg::REG_METHOD) ? {30'd0, method_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg <= kgc_pkg::METHOD_RESET;
        end
        else
        begin
            method_reg <= method_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    // ------------------------------------------------------------------
    logic out_valid_reg, out_valid_next;
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_ready, s2_ready, s2_load, out_load;
    logic in_xfer, month_ok, month_close, month_mid;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s2_load   = s1_valid_reg && s2_ready;
    assign out_load  = s2_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !s2_ready;
    assign in_xfer   = in_valid && !in_stall;

    assign month_ok    = (month <= kgc_pkg::MONTH_LAST);
    assign month_close = (month == kgc_pkg::MONTH_LAST);
    assign month_mid   = (month >= kgc_pkg::MONTH_MID_FIRST) &&
                         (month <= kgc_pkg::MONTH_MID_LAST);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer && month_close)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s2_load)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s2_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Monthly accumulators
    // ------------------------------------------------------------------
    kgc_pkg::kgc_snap_t acc_reg, acc_next, acc_upd, acc_empty;
    kgc_pkg::kgc_snap_t snap_reg, snap_next;
    logic [13:0]        t_ext;
    logic [18:0]        p_ext;

    assign t_ext = {{3{temperature[10]}}, temperature};
    assign p_ext = {3'b000, precipitation};

    always_comb
    begin
        acc_empty           = '0;
        acc_empty.tlow      = 11'sd1023;
        acc_empty.thigh     = 11'h400;
        acc_empty.rmin_mid  = 16'hFFFF;
        acc_empty.rmin_edge = 16'hFFFF;
    end

    // running values including the current sample
    always_comb
    begin
        acc_upd = acc_reg;
        acc_upd.missing = acc_reg.missing | no_data;
        if (month_mid)
        begin
            acc_upd.tsum_mid = acc_reg.tsum_mid + t_ext;
            acc_upd.rsum_mid = acc_reg.rsum_mid + p_ext;
            if (precipitation < acc_reg.rmin_mid)
            begin
                acc_upd.rmin_mid = precipitation;
            end
            if (precipitation > acc_reg.rmax_mid)
            begin
                acc_upd.rmax_mid = precipitation;
            end
        end
        else
        begin
            acc_upd.tsum_edge = acc_reg.tsum_edge + t_ext;
            acc_upd.rsum_edge = acc_reg.rsum_edge + p_ext;
            if (precipitation < acc_reg.rmin_edge)
            begin
                acc_upd.rmin_edge = precipitation;
            end
            if (precipitation > acc_reg.rmax_edge)
            begin
                acc_upd.rmax_edge = precipitation;
            end
        end
        if (temperature < $signed(acc_reg.tlow))
        begin
            acc_upd.tlow = temperature;
        end
        if (temperature > $signed(acc_reg.thigh))
        begin
            acc_upd.thigh = temperature;
        end
        if (temperature > kgc_pkg::T_WARM_MONTH)
        begin
            acc_upd.warm = acc_reg.warm + 4'd1;
        end
    end

    // closing month: hand totals to the snapshot and start a fresh pixel
    always_comb
    begin
        acc_next  = acc_reg;
        snap_next = snap_reg;
        if (in_xfer && month_ok)
        begin
            if (month_close)
            begin
                acc_next  = acc_empty;
                snap_next = acc_upd;
            end
            else
            begin
                acc_next = acc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= acc_empty;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

    // ------------------------------------------------------------------
    // Compare stage
    // ------------------------------------------------------------------
    kgc_pkg::kgc_deriv_t der_reg, der_next;
    logic               peel, no_split, north;
    logic signed [14:0] tsum;
    logic signed [18:0] tsum5;
    logic [19:0]        psum;
    logic [18:0]        pw_sum, ps_sum;
    logic [15:0]        pw_min, ps_min, pw_max, ps_max, pmin;
    logic [22:0]        pw10, ps10, p7;
    logic [21:0]        trop_sum;
    logic [19:0]        pw_min10;
    logic [17:0]        ps_min3;

    assign peel     = (method_reg == kgc_pkg::METHOD_PEEL);
    assign no_split = (method_reg == kgc_pkg::METHOD_NO_SPLIT) || peel;

    always_comb
    begin
        tsum   = $signed({snap_reg.tsum_mid[13], snap_reg.tsum_mid}) +
                 $signed({snap_reg.tsum_edge[13], snap_reg.tsum_edge});
        tsum5  = $signed({{4{tsum[14]}}, tsum} <<< 2) + $signed({{4{tsum[14]}}, tsum});
        psum   = {1'b0, snap_reg.rsum_mid} + {1'b0, snap_reg.rsum_edge};
        north  = $signed(snap_reg.tsum_mid) > $signed(snap_reg.tsum_edge);
        pw_sum = north ? snap_reg.rsum_edge : snap_reg.rsum_mid;
        ps_sum = north ? snap_reg.rsum_mid  : snap_reg.rsum_edge;
        pw_min = north ? snap_reg.rmin_edge : snap_reg.rmin_mid;
        ps_min = north ? snap_reg.rmin_mid  : snap_reg.rmin_edge;
        pw_max = north ? snap_reg.rmax_edge : snap_reg.rmax_mid;
        ps_max = north ? snap_reg.rmax_mid  : snap_reg.rmax_edge;
        pmin   = (snap_reg.rmin_mid < snap_reg.rmin_edge) ? snap_reg.rmin_mid
                                                          : snap_reg.rmin_edge;

        // arid threshold terms: 10*half vs 7*year
        pw10 = ({4'd0, pw_sum} << 3) + ({4'd0, pw_sum} << 1);
        ps10 = ({4'd0, ps_sum} << 3) + ({4'd0, ps_sum} << 1);
        p7   = ({3'd0, psum} << 3) - {3'd0, psum};

        trop_sum = {2'd0, psum} + ({6'd0, pmin} << 4) + ({6'd0, pmin} << 3) + {6'd0, pmin};
        pw_min10 = ({4'd0, pw_min} << 3) + ({4'd0, pw_min} << 1);
        ps_min3  = ({2'd0, ps_min} << 1) + {2'd0, ps_min};

        der_next          = der_reg;
        if (s2_load)
        begin
            der_next.missing  = snap_reg.missing;
            der_next.polar_ef = $signed(snap_reg.thigh) < 11'sd0;
            der_next.polar_et = $signed(snap_reg.thigh) < kgc_pkg::T_POLAR;
            der_next.hot      = tsum >= kgc_pkg::T_SUM_HOT_ARID;
            if (pw10 >= p7)
            begin
                der_next.arid_rhs = tsum5;
            end
            else if (ps10 >= p7)
            begin
                der_next.arid_rhs = tsum5 + kgc_pkg::ARID_OFS_K14;
            end
            else
            begin
                der_next.arid_rhs = tsum5 + kgc_pkg::ARID_OFS_K7;
            end
            der_next.psum            = psum;
            der_next.tropical        = $signed(snap_reg.tlow) >= kgc_pkg::T_TROPICAL;
            der_next.trop_wet        = pmin >= kgc_pkg::P_WET_MONTH;
            der_next.trop_monsoon    = trop_sum >= kgc_pkg::P_MONSOON;
            der_next.trop_winter_dry = no_split || (pw_min < kgc_pkg::P_WET_MONTH);
            der_next.dry_winter      = {4'd0, ps_max} >= pw_min10;
            der_next.dry_summer      = ({2'd0, pw_max} >= ps_min3) &&
                                       (ps_min < (peel ? kgc_pkg::P_DRY_SUM_PEEL
                                                       : kgc_pkg::P_DRY_SUM_ORIG));
            der_next.pw_lt_ps        = pw_sum < ps_sum;
            der_next.temperate       = $signed(snap_reg.tlow) >=
                                       (peel ? kgc_pkg::T_COLD_PEEL : kgc_pkg::T_COLD_ORIG);
            der_next.hot_summer      = $signed(snap_reg.thigh) > kgc_pkg::T_HOT_SUMMER;
            der_next.warm4           = snap_reg.warm >= kgc_pkg::WARM_MONTHS_B;
            der_next.mild_winter     = $signed(snap_reg.tlow) > kgc_pkg::T_SNOW_SEVERE;
        end
    end

    always_ff @(posedge clk)
    begin
        der_reg <= der_next;
    end

    // ------------------------------------------------------------------
    // Decision stage
    // ------------------------------------------------------------------
    logic [4:0]         class_reg, class_next, group_class;
    logic signed [24:0] arid_lhs6, arid_lhs3, arid_rhs_ext;
    logic               dw, ds;
    logic [1:0]         kind, letter;
    logic [3:0]         kind_ofs;

    always_comb
    begin
        arid_lhs6    = $signed({2'b00, ({3'd0, der_reg.psum} << 2) + ({3'd0, der_reg.psum} << 1)});
        arid_lhs3    = $signed({3'b000, ({2'd0, der_reg.psum} << 1) + {2'd0, der_reg.psum}});
        arid_rhs_ext = $signed({{6{der_reg.arid_rhs[18]}}, der_reg.arid_rhs});

        // resolve dry winter against dry summer
        dw = der_reg.dry_winter;
        ds = der_reg.dry_summer;
        if (dw && ds)
        begin
            if (der_reg.pw_lt_ps)
            begin
                ds = 1'b0;
            end
            else
            begin
                dw = 1'b0;
            end
        end
        kind = dw ? 2'd2 : (ds ? 2'd1 : 2'd0);

        // temperature letter a/b/c/d
        if (der_reg.hot_summer)
        begin
            letter = 2'd0;
        end
        else if (der_reg.warm4)
        begin
            letter = 2'd1;
        end
        else if (der_reg.temperate || der_reg.mild_winter)
        begin
            letter = 2'd2;
        end
        else
        begin
            letter = 2'd3;
        end

        // temperate groups step by 3, snow groups by 4
        if (der_reg.temperate)
        begin
            kind_ofs    = ({2'd0, kind} << 1) + {2'd0, kind};
            group_class = kgc_pkg::CLASS_CFA + {1'b0, kind_ofs} + {3'd0, letter};
        end
        else
        begin
            kind_ofs    = {2'd0, kind} << 2;
            group_class = kgc_pkg::CLASS_DFA + {1'b0, kind_ofs} + {3'd0, letter};
        end

        class_next = class_reg;
        if (out_load)
        begin
            priority if (der_reg.missing)
            begin
                class_next = kgc_pkg::CLASS_NONE;
            end
            else if (der_reg.polar_ef)
            begin
                class_next = kgc_pkg::CLASS_EF;
            end
            else if (der_reg.polar_et)
            begin
                class_next = kgc_pkg::CLASS_ET;
            end
            else if (arid_lhs6 < arid_rhs_ext)
            begin
                class_next = der_reg.hot ? kgc_pkg::CLASS_BWH : kgc_pkg::CLASS_BWK;
            end
            else if (arid_lhs3 < arid_rhs_ext)
            begin
                class_next = der_reg.hot ? kgc_pkg::CLASS_BSH : kgc_pkg::CLASS_BSK;
            end
            else if (der_reg.tropical)
            begin
                if (der_reg.trop_wet)
                begin
                    class_next = kgc_pkg::CLASS_AF;
                end
                else if (der_reg.trop_monsoon)
                begin
                    class_next = kgc_pkg::CLASS_AM;
                end
                else if (der_reg.trop_winter_dry)
                begin
                    class_next = kgc_pkg::CLASS_AW;
                end
                else
                begin
                    class_next = kgc_pkg::CLASS_AS;
                end
            end
            else
            begin
                class_next = group_class;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        class_reg <= class_next;
    end

    assign out_valid     = out_valid_reg;
    assign climate_class = class_reg;

endmodule

// ----- tb/kgc_class_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kgc_class_checker
// Watches the sample, class and configuration ports of the classifier,
// rebuilds the yearly totals of each pixel, predicts its climate class and
// compares every class transfer with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module kgc_class_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [3:0]         month,
    input  logic signed [10:0] temperature,
    input  logic [15:0]        precipitation,
    input  logic               no_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [4:0]         climate_class,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 outstanding
);

    // byte address of the method register
    localparam logic [2:0] METHOD_ADDR = {kgc_pkg::REG_METHOD, 2'b00};

    // method as last written through the configuration port
    logic [1:0]         method_now;

    // yearly totals of the pixel being collected
    logic signed [13:0] heat_mid;
    logic signed [13:0] heat_edge;
    logic signed [10:0] coldest;
    logic signed [10:0] warmest;
    logic [3:0]         warm_months;
    logic [18:0]        rain_mid;
    logic [18:0]        rain_edge;
    logic [15:0]        rain_lo_mid;
    logic [15:0]        rain_hi_mid;
    logic [15:0]        rain_lo_edge;
    logic [15:0]        rain_hi_edge;
    logic               gap_flag;

    // classes predicted but not yet seen on the output
    logic [4:0]         class_due[$];
    int                 fail_total;

    task automatic start_pixel();
        heat_mid     = '0;
        heat_edge    = '0;
        coldest      = 11'sd1023;
        warmest      = 11'sh400;
        warm_months  = '0;
        rain_mid     = '0;
        rain_edge    = '0;
        rain_lo_mid  = '1;
        rain_hi_mid  = '0;
        rain_lo_edge = '1;
        rain_hi_edge = '0;
        gap_flag     = 1'b0;
    endtask

    // temperate/snow subtype: dry-season letter then a..d by summer heat and, for snow, winter cold
    function automatic logic [4:0] zone_class(input logic [4:0] base, input int kind,
                                              input logic snow);
        int hi;
        int lo;
        int step;
        hi = int'(warmest);
        lo = int'(coldest);
        if (hi > kgc_pkg::T_HOT_SUMMER)
            step = 0;
        else if (warm_months >= kgc_pkg::WARM_MONTHS_B)
            step = 1;
        else if (!snow || lo > kgc_pkg::T_SNOW_SEVERE)
            step = 2;
        else
            step = 3;
        return base + 5'(kind * (snow ? 4 : 3) + step);
    endfunction

    function automatic logic [4:0] classify_year();
        logic peel;
        logic no_split;
        logic north;
        logic hot;
        logic dry_w;
        logic dry_s;
        int   tm, te, tsum;
        int   rm, re, psum, pmin;
        int   pw_sum, ps_sum, pw_min, ps_min, pw_max, ps_max;
        int   lo, hi, arid_ofs, kind, dry_cap;

        peel     = (method_now == kgc_pkg::METHOD_PEEL);
        no_split = (method_now == kgc_pkg::METHOD_NO_SPLIT) || peel;
        tm   = int'(heat_mid);
        te   = int'(heat_edge);
        tsum = tm + te;
        rm   = int'(rain_mid);
        re   = int'(rain_edge);
        psum = rm + re;
        pmin = (rain_lo_mid < rain_lo_edge) ? int'(rain_lo_mid) : int'(rain_lo_edge);
        lo   = int'(coldest);
        hi   = int'(warmest);

        // summer is the warmer half
        north  = tm > te;
        pw_sum = north ? re : rm;
        ps_sum = north ? rm : re;
        pw_min = north ? int'(rain_lo_edge) : int'(rain_lo_mid);
        ps_min = north ? int'(rain_lo_mid) : int'(rain_lo_edge);
        pw_max = north ? int'(rain_hi_edge) : int'(rain_hi_mid);
        ps_max = north ? int'(rain_hi_mid) : int'(rain_hi_edge);

        // polar
        if (hi < 0)
            return kgc_pkg::CLASS_EF;
        if (hi < kgc_pkg::T_POLAR)
            return kgc_pkg::CLASS_ET;

        // arid: threshold depends on where the rain falls
        if (10 * pw_sum >= 7 * psum)
            arid_ofs = 0;
        else if (10 * ps_sum >= 7 * psum)
            arid_ofs = int'(kgc_pkg::ARID_OFS_K14);
        else
            arid_ofs = int'(kgc_pkg::ARID_OFS_K7);
        hot = tsum >= kgc_pkg::T_SUM_HOT_ARID;
        if (6 * psum < 5 * tsum + arid_ofs)
            return hot ? kgc_pkg::CLASS_BWH : kgc_pkg::CLASS_BWK;
        if (3 * psum < 5 * tsum + arid_ofs)
            return hot ? kgc_pkg::CLASS_BSH : kgc_pkg::CLASS_BSK;

        // equatorial
        if (lo >= kgc_pkg::T_TROPICAL)
        begin
            if (pmin >= int'(kgc_pkg::P_WET_MONTH))
                return kgc_pkg::CLASS_AF;
            if (psum + 25 * pmin >= int'(kgc_pkg::P_MONSOON))
                return kgc_pkg::CLASS_AM;
            if (no_split || pw_min < int'(kgc_pkg::P_WET_MONTH))
                return kgc_pkg::CLASS_AW;
            return kgc_pkg::CLASS_AS;
        end

        // dry season; when both apply the drier half wins
        dry_cap = peel ? int'(kgc_pkg::P_DRY_SUM_PEEL) : int'(kgc_pkg::P_DRY_SUM_ORIG);
        dry_w = ps_max >= 10 * pw_min;
        dry_s = (pw_max >= 3 * ps_min) && (ps_min < dry_cap);
        if (dry_w && dry_s)
        begin
            if (pw_sum < ps_sum)
                dry_s = 1'b0;
            else
                dry_w = 1'b0;
        end
        kind = dry_w ? 2 : (dry_s ? 1 : 0);

        if (lo >= (peel ? kgc_pkg::T_COLD_PEEL : kgc_pkg::T_COLD_ORIG))
            return zone_class(kgc_pkg::CLASS_CFA, kind, 1'b0);
        return zone_class(kgc_pkg::CLASS_DFA, kind, 1'b1);
    endfunction

    // fold one monthly sample into the totals; the closing month predicts
    task automatic take_month(input logic [3:0] mon, input logic signed [10:0] t,
                              input logic [15:0] p, input logic nd);
        if (mon <= kgc_pkg::MONTH_LAST)
        begin
            if (nd)
                gap_flag = 1'b1;
            if (mon >= kgc_pkg::MONTH_MID_FIRST && mon <= kgc_pkg::MONTH_MID_LAST)
            begin
                heat_mid = heat_mid + t;
                rain_mid = rain_mid + p;
                if (p < rain_lo_mid)
                    rain_lo_mid = p;
                if (p > rain_hi_mid)
                    rain_hi_mid = p;
            end
            else
            begin
                heat_edge = heat_edge + t;
                rain_edge = rain_edge + p;
                if (p < rain_lo_edge)
                    rain_lo_edge = p;
                if (p > rain_hi_edge)
                    rain_hi_edge = p;
            end
            if (t < coldest)
                coldest = t;
            if (t > warmest)
                warmest = t;
            if (t > kgc_pkg::T_WARM_MONTH)
                warm_months = warm_months + 4'd1;
            if (mon == kgc_pkg::MONTH_LAST)
            begin
                class_due.push_back(gap_flag ? kgc_pkg::CLASS_NONE : classify_year());
                start_pixel();
            end
        end
    endtask

    task automatic check_class(input logic [4:0] got);
        logic [4:0] want;
        if (class_due.size() == 0)
        begin
            $error("climate_class: nothing expected, actual %0d", got);
            fail_total++;
        end
        else
        begin
            want = class_due.pop_front();
            if (got !== want)
            begin
                $error("climate_class: expected %0d, actual %0d", want, got);
                fail_total++;
            end
        end
    endtask

    // monitor: output first, so a class is checked against older samples only
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_now = kgc_pkg::METHOD_RESET;
            start_pixel();
            class_due.delete();
            fail_total = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_class(climate_class);
            if (in_valid && !in_stall)
                take_month(month, temperature, precipitation, no_data);
            if (psel && penable && pwrite && pready && paddr == METHOD_ADDR)
                method_now = pwdata[1:0];
            fail_count  <= fail_total;
            outstanding <= class_due.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives monthly samples into the climate classifier: a short directed set of
// corner pixels, then phases of random pixels under each method setting with
// random gaps and stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [2:0] METHOD_ADDR     = {kgc_pkg::REG_METHOD, 2'b00};
    localparam logic [1:0] METHOD_SPARE    = 2'd3;
    localparam int         PHASES          = 6;
    localparam int         PHASE_ITEMS     = 250;
    localparam int         HOLD_PHASE      = 2;
    localparam int         LONG_HOLD       = 300;
    localparam int         SETTLE_CYCLES   = 10;
    localparam int         WATCHDOG_LIMIT  = 3000;
    localparam int         T_FIELD_MAX     = 1000;

    localparam logic [1:0] PHASE_METHOD [0:PHASES-1] =
        '{kgc_pkg::METHOD_ORIG, kgc_pkg::METHOD_PEEL, METHOD_SPARE,
          kgc_pkg::METHOD_NO_SPLIT, kgc_pkg::METHOD_PEEL, kgc_pkg::METHOD_ORIG};
    localparam logic PHASE_SEND_IDLE [0:PHASES-1] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    localparam logic PHASE_RECV_IDLE [0:PHASES-1] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    // seasonal swing per month, positive in months 4..8, zero in 3 and 9
    localparam int SEASON_SWING [0:11] = '{-10, -8, -4, 0, 4, 8, 10, 8, 4, 0, -4, -8};

    typedef enum {WET_ALL_YEAR, DRY_WINTER, DRY_SUMMER} rain_season_t;

    logic               clk;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic [3:0]         month         = '0;
    logic signed [10:0] temperature   = '0;
    logic [15:0]        precipitation = '0;
    logic               no_data       = 1'b0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic [4:0]         climate_class;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [2:0]         paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 outstanding;

    logic               send_idle     = 1'b1;
    logic               recv_idle     = 1'b1;
    logic               long_hold_req = 1'b0;
    int                 months_sent   = 0;
    int                 quiet_cycles  = 0;

    koppen_geiger_classifier_top u_dut (.*);

    kgc_class_checker u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // offer one sample and hold it until the transfer
    task automatic offer(input logic [3:0] m, input int t, input int p, input logic nd);
        int gap;
        gap = send_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        month         <= m;
        temperature   <= 11'(t);
        precipitation <= 16'(p);
        no_data       <= nd;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        if (m <= kgc_pkg::MONTH_LAST)
            months_sent++;
    endtask

    // a plausible year: seasonal temperature curve and rain wet all year or with a dry season
    task automatic send_profile_pixel();
        int           mean, amp, wet, swing, t, p;
        logic         flip;
        rain_season_t season;
        mean = int'($urandom_range(0, 900)) - 400;
        amp  = $urandom_range(0, 300);
        flip = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       wet = 100;
            1:       wet = 600;
            2:       wet = 2000;
            default: wet = 8000;
        endcase
        case ($urandom_range(0, 2))
            0:       season = WET_ALL_YEAR;
            1:       season = DRY_WINTER;
            default: season = DRY_SUMMER;
        endcase
        for (int m = 0; m < 12; m++)
        begin
            swing = flip ? -SEASON_SWING[m] : SEASON_SWING[m];
            t = mean + amp * swing / 10 + int'($urandom_range(0, 40)) - 20;
            if (t > T_FIELD_MAX)
                t = T_FIELD_MAX;
            if (t < -T_FIELD_MAX)
                t = -T_FIELD_MAX;
            p = $urandom_range(0, wet);
            if ((season == DRY_WINTER && swing < 0) || (season == DRY_SUMMER && swing > 0))
                p = p / 10;
            offer(4'(m), t, p, $urandom_range(0, 99) < 2);
        end
    endtask

    // arbitrary months, temperatures within +/-T_FIELD_MAX, full rain range, then a closing month
    task automatic send_noise_pixel();
        int n;
        n = $urandom_range(0, 14);
        repeat (n)
            offer(4'($urandom_range(0, 15)), int'($urandom_range(0, 2000)) - T_FIELD_MAX,
                  $urandom_range(0, 65535), $urandom_range(0, 3) == 0);
        offer(kgc_pkg::MONTH_LAST, int'($urandom_range(0, 2000)) - T_FIELD_MAX,
              $urandom_range(0, 65535), $urandom_range(0, 7) == 0);
    endtask

    // drop valid and wait until every class has come out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_method(input logic [1:0] code);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= METHOD_ADDR;
        pwdata  <= {30'd0, code};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // class receiver: random stalls, one long hold-off on request
    initial
    begin : receiver
        int hold;
        forever
        begin
            hold = recv_idle ? $urandom_range(0, 12) : 0;
            if (long_hold_req)
            begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(negedge clk);
            while (!out_valid)
                @(negedge clk);
            @(posedge clk);
        end
    end

    // watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : stimulus
        int goal;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: out-of-range months are dropped, missing flag included
        offer(4'd15, T_FIELD_MAX, 65535, 1'b1);
        offer(4'd12, -T_FIELD_MAX, 0, 1'b0);
        // lone closing month, other months keep their empty values
        offer(kgc_pkg::MONTH_LAST, -T_FIELD_MAX, 0, 1'b0);
        // missing flag on the closing month itself
        offer(kgc_pkg::MONTH_LAST, T_FIELD_MAX, 65535, 1'b1);
        // full year at the top of both fields, rain sums do not wrap
        for (int m = 0; m < 12; m++)
            offer(4'(m), T_FIELD_MAX, 65535, 1'b0);
        // repeated month with an earlier missing flag
        offer(4'd3, -1, 0, 1'b1);
        offer(4'd3, 500, 100, 1'b0);
        offer(kgc_pkg::MONTH_LAST, 250, 200, 1'b0);
        // warmest month exactly at zero
        offer(kgc_pkg::MONTH_LAST, 0, 65535, 1'b0);

        // random phases, one method setting each
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            write_method(PHASE_METHOD[ph]);
            send_idle = PHASE_SEND_IDLE[ph];
            recv_idle = PHASE_RECV_IDLE[ph];
            if (ph == HOLD_PHASE)
                long_hold_req = 1'b1;
            goal = months_sent + PHASE_ITEMS;
            while (months_sent < goal)
            begin
                if ($urandom_range(0, 99) < 80)
                    send_profile_pixel();
                else
                    send_noise_pixel();
            end
        end
        settle();

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- koppen_geiger_classifier_top.f -----
hw/rtl/kgc_pkg.sv
hw/rtl/koppen_geiger_classifier_top.sv
tb/kgc_class_checker.sv
tb/tb_top.sv
